### sv/aerb_pkg.sv
// ----------------------------------------------------------------------------
// aerb_pkg
// types, constants and codes shared by the event batcher modules
// ----------------------------------------------------------------------------
package aerb_pkg;

   localparam int BUFFER_EVENTS = 64;
   localparam int CNT_W = $clog2(BUFFER_EVENTS + 1);
   localparam int IDX_W = (BUFFER_EVENTS > 1) ? $clog2(BUFFER_EVENTS) : 1;

   localparam logic [2:0] CMD_TICK       = 3'd0;
   localparam logic [2:0] CMD_HOST_OPEN  = 3'd1;
   localparam logic [2:0] CMD_HOST_CLOSE = 3'd2;
   localparam logic [2:0] CMD_XFER_DONE  = 3'd3;
   localparam logic [2:0] CMD_BUS_RESET  = 3'd4;
   localparam logic [2:0] CMD_SUSPEND    = 3'd5;
   localparam logic [2:0] CMD_PURGE      = 3'd6;

   localparam logic [15:0] TIMEOUT_RESET = 16'hFFFF;
   localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

   typedef struct packed {
      logic [2:0]  command;
      logic        req_n;
      logic [15:0] address;
      logic [15:0] timestamp;
   } req_payload_type;

   typedef struct packed {
      logic        ack_n;
      logic        is_active;
      logic        ack_pulse;
      logic        dropped;
      logic        event_valid;
      logic [15:0] event_address;
      logic [15:0] event_time;
      logic        last;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic step_en;
      logic emit_status;
      logic emit_event;
      logic clr_idx;
      logic inc_idx;
   } ctl_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic flush_req;
      logic idx_last;
   } dp_status_type;

endpackage

### sv/aerb_ctrl.sv
// ----------------------------------------------------------------------------
// aerb_ctrl
// sequencer: takes transactions and walks the buffer out on a flush
// ----------------------------------------------------------------------------
module aerb_ctrl import aerb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = !status.slot_free;
            if (req_valid && status.slot_free) begin
               cmd.step_en = 1'b1;
               if (status.flush_req) begin
                  cmd.clr_idx = 1'b1;
                  state_in    = ST_READ;
               end else begin
                  cmd.emit_status = 1'b1;
               end
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.slot_free) begin
               cmd.emit_event = 1'b1;
               if (status.idx_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.inc_idx = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### sv/aerb_dp.sv
// ----------------------------------------------------------------------------
// aerb_dp
// handshake state, timeout counter, event buffer and result register
// ----------------------------------------------------------------------------
module aerb_dp import aerb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic [15:0]     csr_wdata,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   input  ctl_cmd_type     cmd,
   output dp_status_type   status
);

   logic [15:0]       timeout_ff;
   logic              phase_ff, phase_in;
   logic              active_ff, active_in;
   logic              ack_ff, ack_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [15:0]       idle_ff, idle_in;
   logic              pulse_ff, pulse_in;
   logic              dropped_ff, dropped_in;
   logic [CNT_W-1:0]  flush_n_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [31:0]       mem_rd_ff;
   logic              rsp_valid_ff;
   rsp_payload_type   rsp_ff;

   logic [31:0]       mem [BUFFER_EVENTS];

   logic              store;
   logic              flush;
   logic [15:0]       idle_inc;
   logic              tmo;

   assign idle_inc = (idle_ff == IDLE_MAX) ? idle_ff : idle_ff + 16'd1;
   assign tmo      = idle_inc >= timeout_ff;

   always_comb begin
      phase_in   = phase_ff;
      active_in  = active_ff;
      ack_in     = ack_ff;
      count_in   = count_ff;
      idle_in    = idle_ff;
      pulse_in   = 1'b0;
      dropped_in = 1'b0;
      store      = 1'b0;
      flush      = 1'b0;
      case (req_data.command)
         CMD_TICK: begin
            idle_in = idle_inc;
            if (!phase_ff) begin
               if (!req_data.req_n) begin
                  ack_in   = 1'b0;
                  phase_in = 1'b1;
                  if (active_ff) begin
                     if (count_ff < CNT_W'(BUFFER_EVENTS)) begin
                        store    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
               end else if (tmo) begin
                  if (active_ff) begin
                     if (count_ff != '0) begin
                        flush   = 1'b1;
                        idle_in = '0;
                     end
                  end else begin
                     pulse_in = 1'b1;
                     idle_in  = '0;
                  end
               end
            end else begin
               if (req_data.req_n) begin
                  ack_in   = 1'b1;
                  phase_in = 1'b0;
                  if (active_ff && count_ff >= CNT_W'(BUFFER_EVENTS)) begin
                     flush   = 1'b1;
                     idle_in = '0;
                  end
               end else if (tmo) begin
                  idle_in  = '0;
                  ack_in   = 1'b1;
                  phase_in = 1'b0;
                  if (active_ff) begin
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                     end
                     dropped_in = 1'b1;
                  end
               end
            end
         end
         CMD_HOST_OPEN: begin
            count_in  = '0;
            ack_in    = 1'b1;
            phase_in  = 1'b0;
            active_in = 1'b1;
         end
         CMD_HOST_CLOSE: begin
            active_in = 1'b0;
         end
         CMD_XFER_DONE: begin
            idle_in   = '0;
            active_in = 1'b1;
         end
         CMD_BUS_RESET: begin
            count_in = '0;
            ack_in   = 1'b1;
            phase_in = 1'b0;
         end
         CMD_SUSPEND: begin
            count_in = '0;
         end
         CMD_PURGE: begin
            active_in = 1'b1;
         end
         default: begin
         end
      endcase
      if (flush) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         phase_ff   <= 1'b0;
         active_ff  <= 1'b0;
         ack_ff     <= 1'b1;
         count_ff   <= '0;
         idle_ff    <= '0;
      end else begin
         if (csr_we) begin
            timeout_ff <= csr_wdata;
         end
         if (cmd.step_en) begin
            phase_ff  <= phase_in;
            active_ff <= active_in;
            ack_ff    <= ack_in;
            count_ff  <= count_in;
            idle_ff   <= idle_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step_en) begin
         pulse_ff   <= pulse_in;
         dropped_ff <= dropped_in;
         flush_n_ff <= count_ff;
      end
   end

   // event buffer
   always_ff @(posedge clock) begin
      if (cmd.step_en && store) begin
         mem[count_ff[IDX_W-1:0]] <= {req_data.address, req_data.timestamp};
      end
      mem_rd_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.clr_idx) begin
         idx_ff <= '0;
      end else if (cmd.inc_idx) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_status || cmd.emit_event) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_status) begin
         rsp_ff.ack_n         <= ack_in;
         rsp_ff.is_active     <= active_in;
         rsp_ff.ack_pulse     <= pulse_in;
         rsp_ff.dropped       <= dropped_in;
         rsp_ff.event_valid   <= 1'b0;
         rsp_ff.event_address <= '0;
         rsp_ff.event_time    <= '0;
         rsp_ff.last          <= 1'b1;
      end else if (cmd.emit_event) begin
         rsp_ff.ack_n         <= ack_ff;
         rsp_ff.is_active     <= active_ff;
         rsp_ff.ack_pulse     <= pulse_ff;
         rsp_ff.dropped       <= dropped_ff;
         rsp_ff.event_valid   <= 1'b1;
         rsp_ff.event_address <= mem_rd_ff[31:16];
         rsp_ff.event_time    <= mem_rd_ff[15:0];
         rsp_ff.last          <= status.idx_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_ff;
   assign status.slot_free = !rsp_valid_ff || !rsp_stall;
   assign status.flush_req = flush;
   assign status.idx_last  = ({1'b0, idx_ff} + 1'b1) == (IDX_W + 1)'(flush_n_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(BUFFER_EVENTS))
      else $error("event count above buffer size");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.step_en && flush |=> count_ff == '0 && flush_n_ff != '0)
      else $error("flush did not clear the buffer");

   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_event |-> (CNT_W)'(idx_ff) < flush_n_ff)
      else $error("flush index past flushed count");

   a_no_step_while_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.step_en |-> status.slot_free && !cmd.emit_event)
      else $error("transaction taken while result slot busy");

endmodule

### sv/aer_handshake_event_batcher.sv
// ----------------------------------------------------------------------------
// aer_handshake_event_batcher
// four-phase address-event receiver that batches events and flushes them
// a transaction that starts no flush has its result registered in the cycle after it is accepted
// takes one transaction per cycle while no flush is under way and the result slot is free
// a flush does one buffer read and one emit per event, each emit waiting for a free result slot
// reset (synchronous, active high): inactive, ack high, buffer empty
// ----------------------------------------------------------------------------
module aer_handshake_event_batcher import aerb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic [15:0]     csr_wdata,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   aerb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   aerb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
